FILE: rtl/core/stp_pkg.sv
package stp_pkg;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 16;
    localparam int ALLOC_W = 7;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_RESTART = 3'd2,
        OP_POLL    = 3'd3,
        OP_STOP    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_RUNNING = 2'd1,
        ST_STOPPED = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   count;
    } t_entry;

    typedef struct packed {
        logic [2:0]         operation;
        logic [IDX_W-1:0]   timer_index;
        logic [CNT_W-1:0]   ticks_value;
        logic               release_flag;
    } t_in_item;

    typedef struct packed {
        logic [ALLOC_W-1:0] allocated_index;
        logic               stopped_flag;
        logic [CNT_W-1:0]   tick_count;
    } t_out_item;

    // One read, one write and one invalidate per cycle into the timer store.
    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        t_entry             wr_data;
        logic               clr_en;
        logic [IDX_W-1:0]   clr_addr;
    } t_mem_req;

endpackage

FILE: rtl/core/stp_store.sv
module stp_store import stp_pkg::*; #(
    parameter int POOL_SIZE = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    t_entry                 r_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0]   r_valid;
    t_entry                 r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
            r_rd_vld  <= r_valid[i_req.rd_addr[AW-1:0]];
        end
    end

    // An entry that has never been written, or was released, reads as free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (i_req.clr_en) begin
                r_valid[i_req.clr_addr[AW-1:0]] <= 1'b0;
            end
        end
    end

    always_comb begin
        o_rdata.status = r_rd_vld ? r_rd_data.status : ST_FREE;
        o_rdata.count  = r_rd_data.count;
    end

endmodule

FILE: rtl/core/stp_ctrl.sv
module stp_ctrl import stp_pkg::*; #(
    parameter int POOL_SIZE = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output t_mem_req  o_mem_req,
    input  t_entry    i_mem_rdata,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_out_item o_res
);

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam logic [CW-1:0] LAST_PTR = CW'(POOL_SIZE);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_POLL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state               r_state,    n_state;
    logic [2:0]           r_op,       n_op;
    logic [AW-1:0]        r_idx,      n_idx;
    logic [CNT_W-1:0]     r_load,     n_load;
    logic                 r_rel,      n_rel;
    logic [CW-1:0]        r_ptr,      n_ptr;
    logic [AW-1:0]        r_wk_addr,  n_wk_addr;
    logic [CNT_W-1:0]     r_tick_cnt, n_tick_cnt;
    logic [ALLOC_W-1:0]   r_alloc,    n_alloc;
    logic                 r_stopped,  n_stopped;

    logic                 in_range;
    logic                 walk_last;
    logic [CNT_W-1:0]     dec_count;

    assign in_range  = i_in_data.timer_index < IDX_W'(POOL_SIZE);
    assign walk_last = (r_ptr == LAST_PTR);
    assign dec_count = i_mem_rdata.count - 16'd1;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_idx      = r_idx;
        n_load     = r_load;
        n_rel      = r_rel;
        n_ptr      = r_ptr;
        n_wk_addr  = r_wk_addr;
        n_tick_cnt = r_tick_cnt;
        n_alloc    = r_alloc;
        n_stopped  = r_stopped;
        o_mem_req  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in_data.operation;
                    n_idx     = i_in_data.timer_index[AW-1:0];
                    n_load    = i_in_data.ticks_value;
                    n_rel     = i_in_data.release_flag;
                    n_alloc   = '0;
                    n_stopped = 1'b0;
                    n_state   = S_DONE;
                    unique case (i_in_data.operation) inside
                        OP_TICK, OP_START: begin
                            // Entry 0 is read now; the walk handles one entry per cycle.
                            if (i_in_data.operation == OP_TICK) begin
                                n_tick_cnt = r_tick_cnt + 16'd1;
                            end
                            o_mem_req.rd_en   = 1'b1;
                            o_mem_req.rd_addr = '0;
                            n_wk_addr         = '0;
                            n_ptr             = CW'(1);
                            n_state           = S_WALK;
                        end
                        OP_RESTART: begin
                            if (in_range) begin
                                o_mem_req.wr_en          = 1'b1;
                                o_mem_req.wr_addr        = i_in_data.timer_index;
                                o_mem_req.wr_data.status = ST_RUNNING;
                                o_mem_req.wr_data.count  = i_in_data.ticks_value;
                            end
                        end
                        OP_POLL: begin
                            if (in_range) begin
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = i_in_data.timer_index;
                                n_state           = S_POLL;
                            end else begin
                                n_stopped = 1'b1;
                            end
                        end
                        OP_STOP: begin
                            if (in_range) begin
                                o_mem_req.clr_en   = 1'b1;
                                o_mem_req.clr_addr = i_in_data.timer_index;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                // Read data belongs to r_wk_addr; the write goes back there while the
                // next entry is read, so the two never touch the same entry.
                if (r_op == OP_TICK) begin
                    if (i_mem_rdata.status == ST_RUNNING) begin
                        o_mem_req.wr_en          = 1'b1;
                        o_mem_req.wr_addr        = IDX_W'(r_wk_addr);
                        o_mem_req.wr_data.status = (dec_count == '0) ? ST_STOPPED : ST_RUNNING;
                        o_mem_req.wr_data.count  = dec_count;
                    end
                    if (walk_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = IDX_W'(r_ptr[AW-1:0]);
                        n_wk_addr         = r_ptr[AW-1:0];
                        n_ptr             = r_ptr + 1'b1;
                    end
                end else begin
                    if (i_mem_rdata.status == ST_FREE) begin
                        o_mem_req.wr_en          = 1'b1;
                        o_mem_req.wr_addr        = IDX_W'(r_wk_addr);
                        o_mem_req.wr_data.status = ST_RUNNING;
                        o_mem_req.wr_data.count  = r_load;
                        n_alloc                  = ALLOC_W'(r_wk_addr);
                        n_state                  = S_DONE;
                    end else if (walk_last) begin
                        n_alloc = ALLOC_W'(POOL_SIZE);
                        n_state = S_DONE;
                    end else begin
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = IDX_W'(r_ptr[AW-1:0]);
                        n_wk_addr         = r_ptr[AW-1:0];
                        n_ptr             = r_ptr + 1'b1;
                    end
                end
            end
            S_POLL: begin
                if (i_mem_rdata.status == ST_STOPPED) begin
                    n_stopped = 1'b1;
                    if (r_rel) begin
                        o_mem_req.clr_en   = 1'b1;
                        o_mem_req.clr_addr = IDX_W'(r_idx);
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tick_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_tick_cnt <= n_tick_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_load    <= n_load;
        r_rel     <= n_rel;
        r_ptr     <= n_ptr;
        r_wk_addr <= n_wk_addr;
        r_alloc   <= n_alloc;
        r_stopped <= n_stopped;
    end

    assign o_in_stall              = (r_state != S_IDLE);
    assign o_res_valid             = (r_state == S_DONE);
    assign o_res.allocated_index   = r_alloc;
    assign o_res.stopped_flag      = r_stopped;
    assign o_res.tick_count        = r_tick_cnt;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_req.rd_en && o_mem_req.wr_en) |-> (o_mem_req.rd_addr != o_mem_req.wr_addr))
        else $error("store read and write hit the same entry in one cycle");

    a_walk_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_ptr != '0) && (r_ptr <= LAST_PTR)))
        else $error("walk pointer left the pool");

    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_IDLE && i_in_valid && i_in_data.operation == OP_TICK)
        |=> $stable(r_tick_cnt))
        else $error("tick counter moved without a tick beat");

endmodule

FILE: rtl/core/software_timer_pool_unit.sv
// Channel  | Direction | Handshake                  | Payload
// in       | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
// out      | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
// One beat is in work at a time. Tick walks every entry, start walks up to the first free
// entry, poll reads one entry unless the index is out of range, and restart, stop and
// unknown codes go straight to the reply.
// The walk over the timer store goes one entry per cycle through its single read port.
// Reset frees every timer at once and clears the tick counter; no clearing pass.
// A stalled output beat is held in the output register while the next beat is worked on.
module software_timer_pool_unit import stp_pkg::*; #(
    parameter int POOL_SIZE = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_mem_req  mem_req;
    t_entry    mem_rdata;
    logic      res_valid;
    logic      res_ready;
    t_out_item res;

    logic      r_out_vld;
    t_out_item r_out_data;

    stp_store #(
        .POOL_SIZE(POOL_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    stp_ctrl #(
        .POOL_SIZE(POOL_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

FILE: tb/tb_software_timer_pool_unit.sv
module tb_software_timer_pool_unit;
    import stp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE    = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 500;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_LIMIT  = 4000;

    // Operation codes the block has no meaning for.
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    bit idle_on = 1'b0;
    bit long_hold_ask = 1'b0;

    software_timer_pool_unit #(
        .POOL_SIZE(POOL_SIZE)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    // Tracks the timer pool as it should be and the replies it owes.
    class timer_pool_board;
        logic [CNT_W-1:0] load_left [POOL_SIZE];
        t_status          timer_state [POOL_SIZE];
        logic [CNT_W-1:0] tick_total;
        t_out_item        replies_due [$];
        int fault_count;
        int replies_seen;
        int ticks_seen;
        int starts_seen;
        int pool_full_seen;
        int restarts_seen;
        int polls_seen;
        int polls_stopped;
        int stops_seen;
        int unknown_seen;

        function new();
            foreach (timer_state[k]) begin
                timer_state[k] = ST_FREE;
                load_left[k] = '0;
            end
            tick_total = '0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void fault(string msg);
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
                $display("%0t ns: MISMATCH %s", $time, msg);
            end
        endfunction

        function void note_op(t_in_item it);
            t_out_item want;
            int        slot;
            bit        in_pool;
            want = '0;
            slot = int'(it.timer_index);
            in_pool = slot < POOL_SIZE;
            case (it.operation)
                OP_TICK: begin
                    ticks_seen++;
                    tick_total++;
                    for (int k = 0; k < POOL_SIZE; k++) begin
                        if (timer_state[k] == ST_RUNNING) begin
                            load_left[k]--;
                            if (load_left[k] == '0) timer_state[k] = ST_STOPPED;
                        end
                    end
                end
                OP_START: begin
                    starts_seen++;
                    want.allocated_index = ALLOC_W'(POOL_SIZE);
                    for (int k = 0; k < POOL_SIZE; k++) begin
                        if (timer_state[k] == ST_FREE) begin
                            load_left[k] = it.ticks_value;
                            timer_state[k] = ST_RUNNING;
                            want.allocated_index = ALLOC_W'(k);
                            break;
                        end
                    end
                    if (want.allocated_index == ALLOC_W'(POOL_SIZE)) pool_full_seen++;
                end
                OP_RESTART: begin
                    restarts_seen++;
                    if (in_pool) begin
                        load_left[slot] = it.ticks_value;
                        timer_state[slot] = ST_RUNNING;
                    end
                end
                OP_POLL: begin
                    polls_seen++;
                    if (!in_pool) begin
                        want.stopped_flag = 1'b1;
                    end else if (timer_state[slot] == ST_STOPPED) begin
                        want.stopped_flag = 1'b1;
                        if (it.release_flag) timer_state[slot] = ST_FREE;
                    end
                    if (want.stopped_flag) polls_stopped++;
                end
                OP_STOP: begin
                    stops_seen++;
                    if (in_pool) timer_state[slot] = ST_FREE;
                end
                default: begin
                    unknown_seen++;
                end
            endcase
            want.tick_count = tick_total;
            replies_due.push_back(want);
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (replies_due.size() == 0) begin
                fault($sformatf("reply with nothing outstanding: index %0d stopped %0d ticks %0d",
                                got.allocated_index, got.stopped_flag, got.tick_count));
                return;
            end
            want = replies_due.pop_front();
            replies_seen++;
            if (got.allocated_index !== want.allocated_index ||
                got.stopped_flag !== want.stopped_flag ||
                got.tick_count !== want.tick_count) begin
                fault($sformatf({"reply %0d: index exp %0d got %0d, stopped exp %0d got %0d, ",
                                 "ticks exp %0d got %0d"}, replies_seen,
                                want.allocated_index, got.allocated_index,
                                want.stopped_flag, got.stopped_flag,
                                want.tick_count, got.tick_count));
            end
        endfunction
    endclass

    timer_pool_board board = new();

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_op(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_reply(o_out_data);
    end

    // Output side: random stall bursts, plus one long hold-off when asked.
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_ask) begin
                long_hold_ask = 1'b0;
                burst = LONG_HOLD;
            end else if (burst == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 12);
            end
            if (burst > 0) begin
                i_out_stall <= 1'b1;
                burst--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #60_000_000;
        $display("tb_software_timer_pool_unit: done, errors");
        $finish;
    end

    function automatic t_in_item make_op(logic [2:0] code, int slot, int load, bit rel);
        t_in_item it;
        it.operation = code;
        it.timer_index = IDX_W'(slot);
        it.ticks_value = CNT_W'(load);
        it.release_flag = rel;
        return it;
    endfunction

    function automatic int pick_slot();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, POOL_SIZE - 1);
        return $urandom_range(0, 63);
    endfunction

    // Mostly short countdowns so timers actually expire within the run.
    function automatic int pick_load();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 6);
        if (roll < 95) return $urandom_range(0, 65535);
        return 0;
    endfunction

    function automatic t_in_item random_op();
        t_in_item it;
        int       roll;
        it = make_op(OP_TICK, pick_slot(), $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            it.operation = OP_TICK;
        end else if (roll < 52) begin
            it.operation = OP_START;
            it.ticks_value = CNT_W'(pick_load());
        end else if (roll < 64) begin
            it.operation = OP_RESTART;
            it.ticks_value = CNT_W'(pick_load());
        end else if (roll < 84) begin
            it.operation = OP_POLL;
        end else if (roll < 95) begin
            it.operation = OP_STOP;
        end else begin
            it.operation = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        end
        return it;
    endfunction

    // Offers one beat, with an optional gap first, and returns once it is taken.
    task automatic push_op(input t_in_item it);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic await_replies();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (board.pending() != 0) board.fault("replies still outstanding after drain limit");
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        // Directed: free, running and stopped timers, out-of-range slots, odd codes.
        push_op(make_op(OP_POLL, 0, 0, 1'b1));
        push_op(make_op(OP_START, 5, 1, 1'b0));
        push_op(make_op(OP_START, 63, 2, 1'b1));
        push_op(make_op(OP_POLL, 63, 'hFFFF, 1'b1));
        push_op(make_op(OP_RESTART, 63, 'hFFFF, 1'b0));
        push_op(make_op(OP_STOP, POOL_SIZE, 0, 1'b0));
        push_op(make_op(OP_FIRST_UNUSED, 63, 'hFFFF, 1'b1));
        push_op(make_op(OP_LAST_UNUSED, 0, 0, 1'b0));
        push_op(make_op(OP_TICK, 0, 0, 1'b0));
        push_op(make_op(OP_POLL, 0, 0, 1'b0));
        push_op(make_op(OP_POLL, 0, 0, 1'b1));
        push_op(make_op(OP_TICK, 63, 'hFFFF, 1'b1));
        push_op(make_op(OP_RESTART, 1, 'hFFFF, 1'b0));
        push_op(make_op(OP_RESTART, 2, 0, 1'b0));
        push_op(make_op(OP_STOP, 1, 0, 1'b0));
        push_op(make_op(OP_START, 0, 3, 1'b0));
        push_op(make_op(OP_START, 0, 'hFFFF, 1'b0));
        push_op(make_op(OP_START, 0, 1, 1'b0));
        push_op(make_op(OP_START, 0, 2, 1'b0));
        push_op(make_op(OP_START, 0, 'h8000, 1'b0));
        push_op(make_op(OP_START, 0, 5, 1'b0));
        push_op(make_op(OP_START, 0, 4, 1'b0));
        push_op(make_op(OP_START, 0, 7, 1'b0));

        push_op(make_op(OP_POLL, 2, 0, 1'b0));
        push_op(make_op(OP_TICK, 0, 0, 1'b0));
        push_op(make_op(OP_POLL, 2, 0, 1'b1));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) idle_on = (n < RANDOM_ITEMS - 80) && ($urandom_range(0, 3) != 0);
            if (n == 150) begin
                idle_on = 1'b0;
                long_hold_ask = 1'b1;
            end
            if (n == 300) begin
                await_replies();
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end
            push_op(random_op());
        end

        await_replies();
        repeat (4 * POOL_SIZE) @(posedge i_clk);
        if (board.pending() != 0) board.fault("replies never arrived");

        $display("Covered %0d ticks, %0d starts (%0d with the pool full), %0d restarts,",
                 board.ticks_seen, board.starts_seen, board.pool_full_seen,
                 board.restarts_seen);
        $display("%0d polls (%0d reporting stopped), %0d stops, %0d unused codes; %0d mismatches.",
                 board.polls_seen, board.polls_stopped, board.stops_seen,
                 board.unknown_seen, board.fault_count);
        if (board.fault_count == 0) begin
            $display("tb_software_timer_pool_unit: done, clean");
        end else begin
            $display("tb_software_timer_pool_unit: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/stp_pkg.sv
rtl/core/stp_store.sv
rtl/core/stp_ctrl.sv
rtl/core/software_timer_pool_unit.sv
tb/tb_software_timer_pool_unit.sv
